/* rtl/core/pfl_pkg.sv */
`default_nettype none

package pfl_pkg;

    // Field widths
    localparam int FREQ_W      = 20;
    localparam int PHASE_W     = 12;
    localparam int LIMIT_W     = 13;
    localparam int RES_W       = 32;
    localparam int PCOUNT_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 20;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FREQ    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_LIMIT = 1'b1;

    // Register reset values
    localparam logic [FREQ_W-1:0]  MIN_FREQ_RESET    = 20'd920000;
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RESET = 13'd2048;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_POINTS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT_SAT = 2'd3;

    // 2*pi * 2^60, rounded up
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611B;

    // Scale factors: 1/4096 turn per kHz -> rad per MHz in Q16.16 (16000*2pi),
    // and 1/4096 turn -> rad in Q16.16 (16*2pi), both with 2^60 fraction
    localparam int SLOPE_K_W = 77;
    localparam int ICPT_K_W  = 67;
    localparam logic [SLOPE_K_W-1:0] SLOPE_K = SLOPE_K_W'(TWO_PI_Q60) * SLOPE_K_W'(16000);
    localparam logic [ICPT_K_W-1:0]  ICPT_K  = ICPT_K_W'(TWO_PI_Q60) << 4;

    // Divider request select
    localparam logic DIV_SLOPE = 1'b0;
    localparam logic DIV_ICPT  = 1'b1;

    // Multiplier operation (operand pair and result destination)
    typedef enum logic [2:0] {
        OP_NQ,
        OP_FF,
        OP_NX,
        OP_FP,
        OP_PQ,
        OP_FX,
        OP_SK,
        OP_IK
    } op_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic mul_start;
        op_t  mul_op;
        logic div_start;
        logic div_sel;
        logic out_load;
    } pfl_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic div_busy;
        logic div_done;
        logic d_zero;
    } pfl_sts_t;

endpackage

`default_nettype wire

/* rtl/core/pfl_mul.sv */
`default_nettype none

// Multi-word multiplier: one 32x32 limb product per cycle, registered,
// then added into the wide accumulator at its limb offset.
module pfl_mul #(
    parameter int OPW = 84
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [OPW-1:0]       a,
    input  wire logic [OPW-1:0]       b,
    output logic                      busy,
    output logic                      done,
    output logic [2*32*((OPW+31)/32)-1:0] product
);

    localparam int LIMBS = (OPW + 31) / 32;
    localparam int LW    = 32 * LIMBS;
    localparam int IW    = $clog2(LIMBS);
    localparam int PW    = $clog2(2 * LIMBS - 1);

    logic [LW-1:0]   a_reg;
    logic [LW-1:0]   b_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   j_reg;
    logic            issue_reg;
    logic            pv_reg;
    logic            busy_reg;
    logic [63:0]     prod_reg;
    logic [PW-1:0]   pos_reg;
    logic [2*LW-1:0] acc_reg;

    assign done    = busy_reg & ~issue_reg & ~pv_reg;
    assign busy    = busy_reg;
    assign product = acc_reg;

    // Limb sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            pv_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            issue_reg <= 1'b1;
            pv_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            pv_reg <= issue_reg;
            if (issue_reg)
            begin
                if (j_reg == IW'(LIMBS - 1))
                begin
                    j_reg <= '0;
                    if (i_reg == IW'(LIMBS - 1))
                        issue_reg <= 1'b0;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            if (done)
                busy_reg <= 1'b0;
        end
    end

    // Partial product and accumulation
    always_ff @(posedge clk)
    begin
        prod_reg <= {32'b0, a_reg[32*i_reg +: 32]} * {32'b0, b_reg[32*j_reg +: 32]};
        pos_reg  <= PW'(i_reg) + PW'(j_reg);
        if (start)
        begin
            a_reg   <= LW'(a);
            b_reg   <= LW'(b);
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ((2*LW)'(prod_reg) << {pos_reg, 5'b00000});
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pfl_div.sv */
`default_nettype none

// Restoring divider: num / (den * 2^60), 33 quotient bits one per cycle,
// then a round-half-up step. The top quotient bit flags overflow.
module pfl_div #(
    parameter int DW = 72,
    parameter int NW = 151
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic               done,
    output logic [32:0]        mag,
    output logic               ovf
);

    localparam int VW    = DW + 93;
    localparam int STEPS = 33;
    localparam int CNW   = $clog2(STEPS + 1);

    logic [VW-1:0]  rem_reg;
    logic [VW-1:0]  dsh_reg;
    logic [DW-1:0]  den_reg;
    logic [32:0]    q_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           rnd_reg;
    logic           done_reg;
    logic [32:0]    mag_reg;
    logic           ovf_reg;
    logic           ge;
    logic           up;

    assign ge   = rem_reg >= dsh_reg;
    assign up   = {rem_reg, 1'b0} >= (VW+1)'({den_reg, 60'b0});
    assign busy = busy_reg;
    assign done = done_reg;
    assign mag  = mag_reg;
    assign ovf  = ovf_reg;

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 1'b0;
                cnt_reg  <= CNW'(STEPS);
            end
            else if (busy_reg)
            begin
                if (rnd_reg)
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNW'(1))
                        rnd_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, shifted divisor and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VW'(num);
            dsh_reg <= VW'({den, 92'b0});
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg && !rnd_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[31:0], ge};
        end
        else if (busy_reg && rnd_reg)
        begin
            mag_reg <= {1'b0, q_reg[31:0]} + 33'(up);
            ovf_reg <= q_reg[32];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pfl_datapath.sv */
`default_nettype none

// Sums, configuration registers, fit arithmetic and result register.
module pfl_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pfl_pkg::pfl_cmd_t                  cmd,
    output pfl_pkg::pfl_sts_t                       sts,
    input  wire logic                               cfg_we,
    input  wire logic [pfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [pfl_pkg::FREQ_W-1:0]         frequency_khz,
    input  wire logic [pfl_pkg::PHASE_W-1:0]        phase_raw,
    output logic signed [pfl_pkg::RES_W-1:0]        slope_q16,
    output logic signed [pfl_pkg::RES_W-1:0]        intercept_q16,
    output logic [pfl_pkg::PCOUNT_W-1:0]            point_count,
    output logic [pfl_pkg::STATUS_W-1:0]            status
);

    localparam int CB    = COUNT_BITS;
    localparam int FW    = 20 + CB;
    localparam int PSW   = 12 + CB;
    localparam int QW    = 40 + CB;
    localparam int XW    = 32 + CB;
    localparam int TW    = 52 + 2 * CB;
    localparam int DWD   = 40 + 2 * CB;
    localparam int SW    = 32 + 2 * CB;
    localparam int OPW   = (TW > pfl_pkg::SLOPE_K_W) ? TW : pfl_pkg::SLOPE_K_W;
    localparam int LW    = 32 * ((OPW + 31) / 32);
    localparam int NUMW  = 119 + 2 * CB;
    localparam int CW    = (CB > pfl_pkg::PCOUNT_W) ? CB : pfl_pkg::PCOUNT_W;

    // Q16.16 saturation of a rounded magnitude with sign
    function automatic logic [31:0] sat_q16(input logic [32:0] m, input logic o,
                                            input logic neg);
        logic [31:0] r;
        if (o)
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (!neg)
            r = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        else if (m > 33'h0_8000_0000)
            r = 32'h8000_0000;
        else
            r = 32'(33'd0 - m);
        return r;
    endfunction

    logic [pfl_pkg::FREQ_W-1:0]  min_freq_reg;
    logic [pfl_pkg::LIMIT_W-1:0] phase_limit_reg;

    logic [FW-1:0]  sum_f_reg;
    logic [PSW-1:0] sum_p_reg;
    logic [QW-1:0]  sum_q_reg;
    logic [XW-1:0]  sum_x_reg;
    logic [CB-1:0]  count_reg;
    logic           sat_reg;

    logic [TW-1:0]  t_reg;
    logic [DWD-1:0] d_reg;
    logic [SW-1:0]  s_mag_reg;
    logic           s_neg_reg;
    logic [TW-1:0]  i_mag_reg;
    logic           i_neg_reg;
    logic [31:0]    slope_val_reg;
    logic [31:0]    icpt_val_reg;

    logic [31:0]                    slope_out_reg;
    logic [31:0]                    icpt_out_reg;
    logic [pfl_pkg::PCOUNT_W-1:0]   pcount_out_reg;
    logic [pfl_pkg::STATUS_W-1:0]   status_out_reg;

    logic [39:0]     ff;
    logic [31:0]     fp;
    logic            qualify;
    logic [OPW-1:0]  mul_a;
    logic [OPW-1:0]  mul_b;
    logic            mul_busy;
    logic            mul_done;
    logic [2*LW-1:0] mul_prod;
    logic [TW-1:0]   prod_t;
    logic            t_lt;
    logic [TW-1:0]   diff_mag;
    logic            div_busy;
    logic            div_done;
    logic [32:0]     div_mag;
    logic            div_ovf;
    logic [CW-1:0]   count_ext;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg    <= pfl_pkg::MIN_FREQ_RESET;
            phase_limit_reg <= pfl_pkg::PHASE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfl_pkg::CFG_MIN_FREQ:    min_freq_reg    <= cfg_data;
                pfl_pkg::CFG_PHASE_LIMIT: phase_limit_reg <= cfg_data[pfl_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample filter and products
    assign qualify = (frequency_khz >= min_freq_reg) &&
                     ({1'b0, phase_raw} < phase_limit_reg);
    assign ff = {20'b0, frequency_khz} * {20'b0, frequency_khz};
    assign fp = {12'b0, frequency_khz} * {20'b0, phase_raw};

    // Running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_f_reg <= '0;
            sum_p_reg <= '0;
            sum_q_reg <= '0;
            sum_x_reg <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            sum_f_reg <= '0;
            sum_p_reg <= '0;
            sum_q_reg <= '0;
            sum_x_reg <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.accept && qualify)
        begin
            if (&count_reg)
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                sum_f_reg <= sum_f_reg + FW'(frequency_khz);
                sum_p_reg <= sum_p_reg + PSW'(phase_raw);
                sum_q_reg <= sum_q_reg + QW'(ff);
                sum_x_reg <= sum_x_reg + XW'(fp);
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            pfl_pkg::OP_NQ: begin mul_a = OPW'(count_reg); mul_b = OPW'(sum_q_reg); end
            pfl_pkg::OP_FF: begin mul_a = OPW'(sum_f_reg); mul_b = OPW'(sum_f_reg); end
            pfl_pkg::OP_NX: begin mul_a = OPW'(count_reg); mul_b = OPW'(sum_x_reg); end
            pfl_pkg::OP_FP: begin mul_a = OPW'(sum_f_reg); mul_b = OPW'(sum_p_reg); end
            pfl_pkg::OP_PQ: begin mul_a = OPW'(sum_p_reg); mul_b = OPW'(sum_q_reg); end
            pfl_pkg::OP_FX: begin mul_a = OPW'(sum_f_reg); mul_b = OPW'(sum_x_reg); end
            pfl_pkg::OP_SK: begin mul_a = OPW'(s_mag_reg); mul_b = OPW'(pfl_pkg::SLOPE_K); end
            pfl_pkg::OP_IK: begin mul_a = OPW'(i_mag_reg); mul_b = OPW'(pfl_pkg::ICPT_K); end
            default:        begin mul_a = '0;              mul_b = '0;                     end
        endcase
    end

    pfl_mul #(
        .OPW (OPW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Signed difference of the held product and the new one
    assign prod_t   = mul_prod[TW-1:0];
    assign t_lt     = t_reg < prod_t;
    assign diff_mag = t_lt ? (prod_t - t_reg) : (t_reg - prod_t);

    // Product capture
    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (cmd.mul_op) inside
                pfl_pkg::OP_NQ, pfl_pkg::OP_NX, pfl_pkg::OP_PQ: t_reg <= prod_t;
                pfl_pkg::OP_FF: d_reg <= t_reg[DWD-1:0] - prod_t[DWD-1:0];
                pfl_pkg::OP_FP:
                begin
                    s_mag_reg <= diff_mag[SW-1:0];
                    s_neg_reg <= t_lt;
                end
                pfl_pkg::OP_FX:
                begin
                    i_mag_reg <= diff_mag;
                    i_neg_reg <= t_lt;
                end
                default: ;
            endcase
        end
    end

    pfl_div #(
        .DW (DWD),
        .NW (NUMW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (mul_prod[NUMW-1:0]),
        .den   (d_reg),
        .busy  (div_busy),
        .done  (div_done),
        .mag   (div_mag),
        .ovf   (div_ovf)
    );

    // Quotient capture with saturation
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            if (cmd.div_sel == pfl_pkg::DIV_SLOPE)
                slope_val_reg <= sat_q16(div_mag, div_ovf, s_neg_reg);
            else
                icpt_val_reg <= sat_q16(div_mag, div_ovf, i_neg_reg);
        end
    end

    // Result register
    assign count_ext = CW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slope_out_reg  <= sts.d_zero ? 32'd0 : slope_val_reg;
            icpt_out_reg   <= sts.d_zero ? 32'd0 : icpt_val_reg;
            pcount_out_reg <= (count_ext > CW'(16'hFFFF)) ? 16'hFFFF
                                                          : count_ext[pfl_pkg::PCOUNT_W-1:0];
            if (count_reg == '0)
                status_out_reg <= pfl_pkg::ST_NO_POINTS;
            else if (sts.d_zero)
                status_out_reg <= pfl_pkg::ST_ZERO_DEN;
            else if (sat_reg)
                status_out_reg <= pfl_pkg::ST_COUNT_SAT;
            else
                status_out_reg <= pfl_pkg::ST_OK;
        end
    end

    assign slope_q16     = slope_out_reg;
    assign intercept_q16 = icpt_out_reg;
    assign point_count   = pcount_out_reg;
    assign status        = status_out_reg;

    assign sts.mul_busy = mul_busy;
    assign sts.mul_done = mul_done;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.d_zero   = (d_reg == '0);

endmodule

`default_nettype wire

/* rtl/core/pfl_ctrl.sv */
`default_nettype none

// Sequencer: accumulate while idle, then walk the fit through the shared
// multiplier and divider and hand the result to the output register.
module pfl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pfl_pkg::pfl_cmd_t      cmd,
    input  wire pfl_pkg::pfl_sts_t sts
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NQ    = 13'b0000000000010,
        S_FF    = 13'b0000000000100,
        S_CHECK = 13'b0000000001000,
        S_NX    = 13'b0000000010000,
        S_FP    = 13'b0000000100000,
        S_PQ    = 13'b0000001000000,
        S_FX    = 13'b0000010000000,
        S_SK    = 13'b0000100000000,
        S_DIVS  = 13'b0001000000000,
        S_IK    = 13'b0010000000000,
        S_DIVI  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   launch_reg;
    logic   out_valid_reg;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_op    = pfl_pkg::OP_NQ;
        cmd.accept    = accept;
        cmd.div_sel   = pfl_pkg::DIV_SLOPE;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept && last)
                    state_next = S_NQ;
            end
            S_NQ, S_FF, S_NX, S_FP, S_PQ, S_FX, S_SK, S_IK:
            begin
                unique case (state_reg)
                    S_NQ:    cmd.mul_op = pfl_pkg::OP_NQ;
                    S_FF:    cmd.mul_op = pfl_pkg::OP_FF;
                    S_NX:    cmd.mul_op = pfl_pkg::OP_NX;
                    S_FP:    cmd.mul_op = pfl_pkg::OP_FP;
                    S_PQ:    cmd.mul_op = pfl_pkg::OP_PQ;
                    S_FX:    cmd.mul_op = pfl_pkg::OP_FX;
                    S_SK:    cmd.mul_op = pfl_pkg::OP_SK;
                    default: cmd.mul_op = pfl_pkg::OP_IK;
                endcase
                cmd.mul_start = launch_reg;
                if (!launch_reg && sts.mul_done)
                begin
                    unique case (state_reg)
                        S_NQ:    state_next = S_FF;
                        S_FF:    state_next = S_CHECK;
                        S_NX:    state_next = S_FP;
                        S_FP:    state_next = S_PQ;
                        S_PQ:    state_next = S_FX;
                        S_FX:    state_next = S_SK;
                        S_SK:    state_next = S_DIVS;
                        default: state_next = S_DIVI;
                    endcase
                end
            end
            S_CHECK:
            begin
                state_next = sts.d_zero ? S_OUT : S_NX;
            end
            S_DIVS:
            begin
                cmd.mul_op    = pfl_pkg::OP_SK;
                cmd.div_start = launch_reg;
                cmd.div_sel   = pfl_pkg::DIV_SLOPE;
                if (!launch_reg && sts.div_done)
                    state_next = S_IK;
            end
            S_DIVI:
            begin
                cmd.mul_op    = pfl_pkg::OP_IK;
                cmd.div_start = launch_reg;
                cmd.div_sel   = pfl_pkg::DIV_ICPT;
                if (!launch_reg && sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, launch flag and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= (state_next != state_reg);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.mul_busy && !sts.div_busy)
        else $error("divider started while a unit is busy");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input still open after last request");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result load did not raise valid");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> !sts.div_busy)
        else $error("multiplier and divider active together");
`endif

endmodule

`default_nettype wire

/* rtl/core/phase_frequency_line_fit_core.sv */
`default_nettype none

// Least-squares line fit of phase (1/4096 turn) against frequency (kHz).
// Samples are taken one per clock while the block is idle; each qualifying
// sample (frequency >= min_frequency_khz, phase < phase_limit) is added to
// exact sums in the same cycle. The request marked last is accumulated and
// then starts the fit: eight multi-word products on one shared 32x32
// multiplier and two divisions, with the input closed throughout (only the
// first two products are made when the denominator is zero). Slope (rad/MHz)
// and intercept (rad) come out as saturated, rounded Q16.16 with the point
// count and a status code; the sums then clear. A finished result waits in
// the output register while the next set is accumulated. Register writes
// take effect at once and are meant for idle periods.
module phase_frequency_line_fit_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [pfl_pkg::FREQ_W-1:0]         frequency_khz,
    input  wire logic [pfl_pkg::PHASE_W-1:0]        phase_raw,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [pfl_pkg::RES_W-1:0]        slope_q16,
    output logic signed [pfl_pkg::RES_W-1:0]        intercept_q16,
    output logic [pfl_pkg::PCOUNT_W-1:0]            point_count,
    output logic [pfl_pkg::STATUS_W-1:0]            status
);

    pfl_pkg::pfl_cmd_t cmd;
    pfl_pkg::pfl_sts_t sts;

    pfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pfl_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frequency_khz (frequency_khz),
        .phase_raw     (phase_raw),
        .slope_q16     (slope_q16),
        .intercept_q16 (intercept_q16),
        .point_count   (point_count),
        .status        (status)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_phase_frequency_line_fit_core.sv */
`default_nettype none

module tb_phase_frequency_line_fit_core;

    localparam int COUNT_BITS = 16;
    localparam logic [255:0] MAX_POINTS = (256'd1 << COUNT_BITS) - 1;
    // wait allowance for a fit, well beyond what the fit itself takes
    localparam int FIT_CYCLES = 400;

    typedef logic [255:0] wide_t;

    typedef struct {
        logic signed [pfl_pkg::RES_W-1:0] slope;
        logic signed [pfl_pkg::RES_W-1:0] icpt;
        logic [pfl_pkg::PCOUNT_W-1:0]     count;
        logic [pfl_pkg::STATUS_W-1:0]     stat;
    } fit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [pfl_pkg::CFG_INDEX_W-1:0] cfg_index = pfl_pkg::CFG_MIN_FREQ;
    logic [pfl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [pfl_pkg::FREQ_W-1:0] frequency_khz = '0;
    logic [pfl_pkg::PHASE_W-1:0] phase_raw = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [pfl_pkg::RES_W-1:0] slope_q16;
    logic signed [pfl_pkg::RES_W-1:0] intercept_q16;
    logic [pfl_pkg::PCOUNT_W-1:0] point_count;
    logic [pfl_pkg::STATUS_W-1:0] status;

    // predictor state
    logic [pfl_pkg::FREQ_W-1:0] min_freq_cfg = pfl_pkg::MIN_FREQ_RESET;
    logic [pfl_pkg::LIMIT_W-1:0] phase_limit_cfg = pfl_pkg::PHASE_LIMIT_RESET;
    wide_t sum_f, sum_p, sum_ff, sum_fp, n_points;
    logic count_full;

    fit_t pending_fits[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int fits_checked = 0;
    int samples_sent = 0;
    int cfg_writes = 0;

    phase_frequency_line_fit_core #(.COUNT_BITS(COUNT_BITS)) dut (.*);

    always #1 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // rounded, saturated Q16.16 of sign*num/den
    function automatic logic signed [pfl_pkg::RES_W-1:0] round_sat(wide_t num, wide_t den,
                                                                   bit neg);
        wide_t q;
        wide_t r;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den)
            q = q + 1;
        if (!neg)
            return (q > 256'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        if (q > 256'h8000_0000)
            q = 256'h8000_0000;
        return -q[31:0];
    endfunction

    // least-squares fit over the current sums
    function automatic fit_t line_fit();
        fit_t res;
        wide_t nq, ff, d, den, a, b;
        res.slope = '0;
        res.icpt = '0;
        res.count = (n_points > 256'hFFFF) ? 16'hFFFF : n_points[15:0];
        nq = n_points * sum_ff;
        ff = sum_f * sum_f;
        if (n_points == 0)
            res.stat = pfl_pkg::ST_NO_POINTS;
        else if (ff >= nq)
            res.stat = pfl_pkg::ST_ZERO_DEN;
        else
        begin
            d = nq - ff;
            den = d << 60;
            a = n_points * sum_fp;
            b = sum_f * sum_p;
            res.slope = round_sat(((a >= b) ? a - b : b - a) * 16000 * pfl_pkg::TWO_PI_Q60,
                                  den, a < b);
            a = sum_p * sum_ff;
            b = sum_f * sum_fp;
            res.icpt = round_sat(((a >= b) ? a - b : b - a) * 16 * pfl_pkg::TWO_PI_Q60,
                                 den, a < b);
            res.stat = count_full ? pfl_pkg::ST_COUNT_SAT : pfl_pkg::ST_OK;
        end
        return res;
    endfunction

    function automatic void clear_sums();
        sum_f = 0;
        sum_p = 0;
        sum_ff = 0;
        sum_fp = 0;
        n_points = 0;
        count_full = 1'b0;
    endfunction

    // send one sample request and update the prediction once it is taken
    task automatic send_sample(logic [pfl_pkg::FREQ_W-1:0] f, logic [pfl_pkg::PHASE_W-1:0] p,
                               logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frequency_khz <= f;
        phase_raw <= p;
        last <= l;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        if (f >= min_freq_cfg && p < phase_limit_cfg)
        begin
            if (n_points >= MAX_POINTS)
                count_full = 1'b1;
            else
            begin
                sum_f += f;
                sum_p += p;
                sum_ff += wide_t'(f) * f;
                sum_fp += wide_t'(f) * p;
                n_points++;
            end
        end
        if (l)
        begin
            pending_fits.push_back(line_fit());
            clear_sums();
        end
    endtask

    task automatic end_stream();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for the block to drain, then hold off for the fit latency
    task automatic wait_drained();
        end_stream();
        while (pending_fits.size() != 0)
            @(posedge clk);
        repeat (FIT_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [pfl_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pfl_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pfl_pkg::CFG_MIN_FREQ)
            min_freq_cfg = val[pfl_pkg::FREQ_W-1:0];
        else
            phase_limit_cfg = val[pfl_pkg::LIMIT_W-1:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_filter(logic [pfl_pkg::FREQ_W-1:0] fmin,
                              logic [pfl_pkg::LIMIT_W-1:0] plim);
        wait_drained();
        write_cfg(pfl_pkg::CFG_MIN_FREQ, fmin);
        write_cfg(pfl_pkg::CFG_PHASE_LIMIT, pfl_pkg::CFG_DATA_W'(plim));
    endtask

    // result checker
    always @(posedge clk)
    begin
        fit_t exp_fit;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected fit: slope %0d icpt %0d count %0d status %0d",
                             slope_q16, intercept_q16, point_count, status);
            end
            else
            begin
                exp_fit = pending_fits.pop_front();
                fits_checked++;
                if (slope_q16 !== exp_fit.slope || intercept_q16 !== exp_fit.icpt ||
                    point_count !== exp_fit.count || status !== exp_fit.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("fit mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_fit.slope, exp_fit.icpt, exp_fit.count, exp_fit.stat,
                                 slope_q16, intercept_q16, point_count, status);
                end
            end
        end
    end

    // reset-value filter: empty set, single point, equal frequencies, extremes
    task automatic test_directed();
        send_sample(20'd0, 12'd0, 1'b1);
        send_sample(20'd930000, 12'd100, 1'b1);
        send_sample(20'd950000, 12'd10, 1'b0);
        send_sample(20'd950000, 12'd900, 1'b1);
        send_sample(20'd920000, 12'd0, 1'b0);
        send_sample(20'd1048575, 12'd2047, 1'b0);
        send_sample(20'd919999, 12'd5, 1'b0);
        send_sample(20'd990000, 12'd2048, 1'b0);
        send_sample(20'd990000, 12'd4095, 1'b0);
        send_sample(20'd1000000, 12'd1500, 1'b1);
        // falling phase: negative slope
        send_sample(20'd925000, 12'd2000, 1'b0);
        send_sample(20'd1040000, 12'd30, 1'b0);
        send_sample(20'd980000, 12'd1111, 1'b1);
        // steep slope for saturation
        send_sample(20'd1000000, 12'd0, 1'b0);
        send_sample(20'd1000001, 12'd2047, 1'b1);
        send_sample(20'd1000001, 12'd0, 1'b0);
        send_sample(20'd1000000, 12'd2047, 1'b1);
    endtask

    // register extremes: everything passes, then nothing passes
    task automatic test_filter_extremes();
        set_filter(20'd0, 13'd4096);
        send_sample(20'd0, 12'd4095, 1'b0);
        send_sample(20'd1048575, 12'd0, 1'b0);
        send_sample(20'd1, 12'd4095, 1'b1);
        send_sample(20'd0, 12'd4095, 1'b0);
        send_sample(20'd2, 12'd0, 1'b1);
        set_filter(20'd1048575, 13'd0);
        send_sample(20'd1048575, 12'd0, 1'b0);
        send_sample(20'd1048575, 12'd4095, 1'b1);
    endtask

    // random sets, mostly well-formed, under the given idle mix
    task automatic test_random(int sender_pct, int receiver_pct, int n_items);
        int sent, len, k;
        logic [pfl_pkg::FREQ_W-1:0] fmin, f;
        logic [pfl_pkg::LIMIT_W-1:0] plim;
        logic [pfl_pkg::PHASE_W-1:0] p;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent % 200 == 0)
            begin
                case ($urandom_range(3))
                    0: fmin = 20'($urandom_range(1048575));
                    1: fmin = 20'($urandom_range(1000));
                    2: fmin = 20'($urandom_range(1048575, 1040000));
                    default: fmin = 20'($urandom_range(950000, 900000));
                endcase
                plim = ($urandom_range(3) == 0) ? 13'd4096 : 13'($urandom_range(4096, 1));
                wait_drained();
                send_idle_pct = sender_pct;
                recv_idle_pct = receiver_pct;
                write_cfg(pfl_pkg::CFG_MIN_FREQ, fmin);
                write_cfg(pfl_pkg::CFG_PHASE_LIMIT, pfl_pkg::CFG_DATA_W'(plim));
            end
            len = $urandom_range(12);
            for (k = 0; k <= len; k++)
            begin
                if ($urandom_range(99) < 85)
                begin
                    f = 20'($urandom_range(1048575, min_freq_cfg));
                    p = (phase_limit_cfg == 0) ? 12'($urandom)
                        : 12'($urandom_range(phase_limit_cfg - 1));
                end
                else
                begin
                    f = 20'($urandom);
                    p = 12'($urandom);
                end
                send_sample(f, p, k == len);
                sent++;
            end
        end
    endtask

    initial
    begin
        clear_sums();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        recv_idle_pct = 0;
        test_directed();
        test_filter_extremes();
        test_random(16, 79, 630);
        test_random(79, 16, 630);
        test_random(0, 0, 640);
        wait_drained();
        $display("Covered %0d samples, %0d fits checked, %0d register writes,",
                 samples_sent, fits_checked, cfg_writes);
        $display("including empty, single-point and equal-frequency sets; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_fits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/pfl_pkg.sv
rtl/core/pfl_mul.sv
rtl/core/pfl_div.sv
rtl/core/pfl_datapath.sv
rtl/core/pfl_ctrl.sv
rtl/core/phase_frequency_line_fit_core.sv
tb/sv/tb_phase_frequency_line_fit_core.sv
